FILE: hdl/bdac_pkg.sv
// Package for the binary to decimal ASCII converter.
// Shared constants, the digit-count function and the converter status type.
// No dependencies.
package bdac_pkg;

  localparam int unsigned DEF_INPUT_BITS = 31;
  localparam int unsigned DIGIT_W        = 4;
  localparam int unsigned CHAR_W         = 6;

  localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;
  localparam logic [CHAR_W-1:0] CHAR_NUL   = 6'd0;

  // Decimal digits of 2**bits - 1: floor(bits * log10(2)) + 1.
  // 1233/4096 approximates log10(2) closely enough for bits up to 63.
  function automatic int unsigned num_digits(input int unsigned bits);
    return ((bits * 1233) >> 12) + 1;
  endfunction

  typedef struct packed {
    logic busy;
    logic done;
  } bdac_status_t;

endpackage

FILE: hdl/bdac_if.sv
// Valid/ready channel interfaces for the converter's request and character streams.
// Depends on bdac_pkg.
interface bdac_in_if #(
  parameter int unsigned INPUT_BITS = bdac_pkg::DEF_INPUT_BITS
);
  logic                  valid;
  logic                  ready;
  logic [INPUT_BITS-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface bdac_out_if;
  import bdac_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] character;
  logic              last;

  modport source (output valid, output character, output last, input ready);
  modport sink   (input valid, input character, input last, output ready);
endinterface

FILE: hdl/bdac_dabble.sv
// Bit-serial double-dabble: shifts the binary value into a BCD register one bit
// per cycle, correcting every digit by +3 when it is 5 or more. Depends on bdac_pkg.
module bdac_dabble #(
  parameter int unsigned INPUT_BITS = bdac_pkg::DEF_INPUT_BITS,
  parameter int unsigned NUM_DIGITS = bdac_pkg::num_digits(INPUT_BITS)
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       start,
  input  logic [INPUT_BITS-1:0]                      value,
  output bdac_pkg::bdac_status_t                     status,
  output logic [NUM_DIGITS*bdac_pkg::DIGIT_W-1:0]    bcd
);
  import bdac_pkg::*;

  localparam int unsigned BCD_W = NUM_DIGITS * DIGIT_W;
  localparam int unsigned CNT_W = $clog2(INPUT_BITS + 1);

  typedef enum logic {ST_IDLE, ST_RUN} state_t;

  state_t                state_r, state_nxt;
  logic [INPUT_BITS-1:0] sh_r, sh_nxt;
  logic [BCD_W-1:0]      bcd_r, bcd_nxt;
  logic [BCD_W-1:0]      bcd_adj;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;

  always_comb begin
    for (int d = 0; d < NUM_DIGITS; d++) begin
      if (bcd_r[d*DIGIT_W +: DIGIT_W] >= 4'd5) begin
        bcd_adj[d*DIGIT_W +: DIGIT_W] = bcd_r[d*DIGIT_W +: DIGIT_W] + 4'd3;
      end else begin
        bcd_adj[d*DIGIT_W +: DIGIT_W] = bcd_r[d*DIGIT_W +: DIGIT_W];
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    sh_nxt    = sh_r;
    bcd_nxt   = bcd_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          sh_nxt    = value;
          bcd_nxt   = '0;
          cnt_nxt   = CNT_W'(INPUT_BITS);
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (cnt_r == '0) begin
          state_nxt = ST_IDLE;
        end else begin
          bcd_nxt = {bcd_adj[BCD_W-2:0], sh_r[INPUT_BITS-1]};
          sh_nxt  = {sh_r[INPUT_BITS-2:0], 1'b0};
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    sh_r  <= sh_nxt;
    bcd_r <= bcd_nxt;
    cnt_r <= cnt_nxt;
  end

  assign status.busy = (state_r != ST_IDLE);
  assign status.done = (state_r == ST_RUN) && (cnt_r == '0);
  assign bcd         = bcd_r;

endmodule

FILE: hdl/binary_to_decimal_ascii_core.sv
// Binary to decimal ASCII converter. Each request carries an unsigned
// INPUT_BITS-bit value; the block answers with its decimal digits as ASCII
// characters, most significant first and without leading zeros, then a zero
// character flagged last (a value of zero gives only that character). One request
// is in work at a time. A request first passes through the bit-serial
// double-dabble loop, then the shift-out register steps through every BCD digit
// position (NUM_DIGITS, 10 at the default 31 bits), whether the digit is sent or
// dropped as a leading zero, and holds while the output is stalled. The block is
// ready for the next request once it has issued the terminator.
// Depends on bdac_pkg, bdac_if and bdac_dabble.
module binary_to_decimal_ascii_core #(
  parameter int unsigned INPUT_BITS = bdac_pkg::DEF_INPUT_BITS
) (
  input logic      clk,
  input logic      rst_n,
  bdac_in_if.sink  in_ch,
  bdac_out_if.source out_ch
);
  import bdac_pkg::*;

  localparam int unsigned NUM_DIGITS = num_digits(INPUT_BITS);
  localparam int unsigned BCD_W      = NUM_DIGITS * DIGIT_W;
  localparam int unsigned DCNT_W     = $clog2(NUM_DIGITS + 1);

  typedef enum logic [1:0] {ST_IDLE, ST_CONV, ST_EMIT} state_t;

  state_t             state_r, state_nxt;
  logic [BCD_W-1:0]   bcd_r, bcd_nxt;
  logic [DCNT_W-1:0]  dcnt_r, dcnt_nxt;
  logic               started_r, started_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]  out_char_r, out_char_nxt;
  logic               out_last_r, out_last_nxt;

  bdac_status_t       conv_stat;
  logic [BCD_W-1:0]   conv_bcd;
  logic               in_accept;
  logic               slot_free;
  logic [DIGIT_W-1:0] top_digit;

  assign in_accept = in_ch.valid && in_ch.ready;
  assign slot_free = !out_valid_r || out_ch.ready;
  assign top_digit = bcd_r[BCD_W-1 -: DIGIT_W];

  bdac_dabble #(
    .INPUT_BITS (INPUT_BITS),
    .NUM_DIGITS (NUM_DIGITS)
  ) u_dabble (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (in_accept),
    .value  (in_ch.value),
    .status (conv_stat),
    .bcd    (conv_bcd)
  );

  always_comb begin
    state_nxt     = state_r;
    bcd_nxt       = bcd_r;
    dcnt_nxt      = dcnt_r;
    started_nxt   = started_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          state_nxt = ST_CONV;
        end
      end
      ST_CONV: begin
        if (conv_stat.done) begin
          bcd_nxt     = conv_bcd;
          dcnt_nxt    = DCNT_W'(NUM_DIGITS);
          started_nxt = 1'b0;
          state_nxt   = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          if (dcnt_r == '0) begin
            // terminator
            out_valid_nxt = 1'b1;
            out_char_nxt  = CHAR_NUL;
            out_last_nxt  = 1'b1;
            state_nxt     = ST_IDLE;
          end else begin
            bcd_nxt  = {bcd_r[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
            dcnt_nxt = dcnt_r - 1'b1;
            if (started_r || (top_digit != '0)) begin
              started_nxt   = 1'b1;
              out_valid_nxt = 1'b1;
              out_char_nxt  = ASCII_ZERO | CHAR_W'(top_digit);
              out_last_nxt  = 1'b0;
            end
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    bcd_r      <= bcd_nxt;
    dcnt_r     <= dcnt_nxt;
    started_r  <= started_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign in_ch.ready      = (state_r == ST_IDLE) && !conv_stat.busy;
  assign out_ch.valid     = out_valid_r;
  assign out_ch.character = out_char_r;
  assign out_ch.last      = out_last_r;

endmodule

FILE: hdl/bdac_checker.sv
// Port-level checks for binary_to_decimal_ascii_core, bound to every instance.
// Depends on bdac_pkg and the top level's interface ports.
module bdac_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [bdac_pkg::CHAR_W-1:0] out_character,
  input logic                        out_last
);
  import bdac_pkg::*;

  // one request at a time: no back-to-back acceptance
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while previous one in work");

  a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |->
      (out_character >= ASCII_ZERO) && (out_character <= ASCII_ZERO + 6'd9))
    else $error("digit character out of range");

  a_term_nul: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> out_character == CHAR_NUL)
    else $error("terminator is not a zero byte");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_character) && $stable(out_last))
    else $error("stalled output changed");

endmodule

bind binary_to_decimal_ascii_core bdac_checker u_bdac_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_character (out_ch.character),
  .out_last      (out_ch.last)
);
